// File: design/edf_pkg.sv
// shared types and codes for the edf tick scheduler
// request and result payloads, per-cell command bundle, function codes
// no dependencies
package edf_pkg;

    localparam int CFG_W  = 4;
    localparam int SLOT_W = 3;
    localparam int WORK_W = 16;
    localparam int OUT_TIME_W = 32;

    localparam logic [1:0] FUNC_LOAD    = 2'd0;
    localparam logic [1:0] FUNC_TICK    = 2'd1;
    localparam logic [1:0] FUNC_RESTART = 2'd2;

    typedef struct packed {
        logic [1:0]        func;
        logic [SLOT_W-1:0] task_slot;
        logic [WORK_W-1:0] period;
        logic [WORK_W-1:0] exec_time;
        logic [WORK_W-1:0] rel_deadline;
    } t_in_req;

    typedef struct packed {
        logic                  idle;
        logic [SLOT_W-1:0]     task_number;
        logic [OUT_TIME_W-1:0] tick_time;
        logic                  job_done;
    } t_out_res;

    // broadcast from the controller to every cell
    typedef struct packed {
        logic              load;
        logic              restart;
        logic [SLOT_W-1:0] slot;
        logic [WORK_W-1:0] period;
        logic [WORK_W-1:0] exec_time;
        logic [WORK_W-1:0] rel_deadline;
    } t_cell_cmd;

endpackage

// File: design/edf_tick_scheduler.sv
// Earliest-deadline-first scheduler over MAX_TASKS periodic task slots, one
// time unit per tick request. Load and restart requests take effect in the
// cycle they are accepted and give no result. A tick request runs the
// selection through a chain of slot cells, one cell per cycle, so a tick
// holds the input until the last cell has answered and its result is
// registered, and only then is the next request taken; a stalled output
// with a result still waiting holds it longer. The result register frees
// the input side while a result waits to be taken.
// depends on edf_pkg and edf_cell
module edf_tick_scheduler #(
    parameter int MAX_TASKS = 8,
    parameter int TIME_BITS = 32
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [edf_pkg::CFG_W-1:0] i_cfg_wdata,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  edf_pkg::t_in_req          i_in_req,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output edf_pkg::t_out_res         o_out_res
);

    localparam int IDX_BITS = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int CNT_BITS = $clog2(MAX_TASKS + 1);
    localparam logic [TIME_BITS-1:0] TIME_MAX = '1;

    logic [edf_pkg::CFG_W-1:0] r_count;
    logic [TIME_BITS-1:0]      r_now, n_now;
    logic                      r_busy, n_busy;
    logic [CNT_BITS-1:0]       r_cnt, n_cnt;
    logic                      r_out_valid, n_out_valid;
    edf_pkg::t_out_res         r_out, n_out;

    logic                      w_accept;
    logic                      w_finish;
    logic [63:0]               w_now_ext;
    edf_pkg::t_cell_cmd        w_cmd;

    logic                      w_found [MAX_TASKS+1];
    logic [IDX_BITS-1:0]       w_idx   [MAX_TASKS+1];
    logic [TIME_BITS-1:0]      w_dl    [MAX_TASKS+1];
    logic                      w_fin   [MAX_TASKS+1];

    assign w_accept = i_in_valid && !r_busy;
    // chain has settled once every cell has seen the stable slot state
    assign w_finish = r_busy && (r_cnt == CNT_BITS'(MAX_TASKS))
                      && (!r_out_valid || !i_out_stall);

    always_comb begin
        w_cmd.load         = w_accept && (i_in_req.func == edf_pkg::FUNC_LOAD);
        w_cmd.restart      = w_accept && (i_in_req.func == edf_pkg::FUNC_RESTART);
        w_cmd.slot         = i_in_req.task_slot;
        w_cmd.period       = i_in_req.period;
        w_cmd.exec_time    = i_in_req.exec_time;
        w_cmd.rel_deadline = i_in_req.rel_deadline;
    end

    assign w_found[0] = 1'b0;
    assign w_idx[0]   = '0;
    assign w_dl[0]    = '0;
    assign w_fin[0]   = 1'b0;

    for (genvar g = 0; g < MAX_TASKS; g++) begin : g_cell
        logic w_grant;
        assign w_grant = w_finish && w_found[MAX_TASKS]
                         && (w_idx[MAX_TASKS] == IDX_BITS'(g));
        edf_cell #(
            .CELL_IDX  (g),
            .IDX_BITS  (IDX_BITS),
            .TIME_BITS (TIME_BITS)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_cmd       (w_cmd),
            .i_grant     (w_grant),
            .i_count     (r_count),
            .i_now       (r_now),
            .i_tok_found (w_found[g]),
            .i_tok_idx   (w_idx[g]),
            .i_tok_dl    (w_dl[g]),
            .i_tok_fin   (w_fin[g]),
            .o_tok_found (w_found[g+1]),
            .o_tok_idx   (w_idx[g+1]),
            .o_tok_dl    (w_dl[g+1]),
            .o_tok_fin   (w_fin[g+1])
        );
    end

    assign w_now_ext = 64'(r_now);

    always_comb begin
        n_now       = r_now;
        n_busy      = r_busy;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
        if (w_accept) begin
            if (i_in_req.func == edf_pkg::FUNC_TICK) begin
                n_busy = 1'b1;
                n_cnt  = '0;
            end else if (i_in_req.func == edf_pkg::FUNC_RESTART) begin
                n_now = '0;
            end
        end
        if (r_busy && (r_cnt != CNT_BITS'(MAX_TASKS))) begin
            n_cnt = r_cnt + CNT_BITS'(1);
        end
        if (w_finish) begin
            n_busy           = 1'b0;
            n_out_valid      = 1'b1;
            n_out.idle       = !w_found[MAX_TASKS];
            n_out.task_number = w_found[MAX_TASKS]
                                ? edf_pkg::SLOT_W'(w_idx[MAX_TASKS]) : '0;
            n_out.tick_time  = (w_now_ext > 64'hFFFF_FFFF)
                               ? '1 : w_now_ext[edf_pkg::OUT_TIME_W-1:0];
            n_out.job_done   = w_found[MAX_TASKS] && w_fin[MAX_TASKS];
            n_now            = (r_now == TIME_MAX) ? r_now : r_now + TIME_BITS'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_now       <= '0;
            r_busy      <= 1'b0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_count <= i_cfg_wdata;
            end
            r_now       <= n_now;
            r_busy      <= n_busy;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_in_stall  = r_busy;
    assign o_out_valid = r_out_valid;
    assign o_out_res   = r_out;

endmodule

// File: design/edf_cell.sv
// one task slot of the edf scheduler: slot state plus one stage of the
// selection chain that compares its deadline against the incoming best
// depends on edf_pkg
module edf_cell #(
    parameter int CELL_IDX  = 0,
    parameter int IDX_BITS  = 3,
    parameter int TIME_BITS = 32
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  edf_pkg::t_cell_cmd          i_cmd,
    input  logic                        i_grant,
    input  logic [edf_pkg::CFG_W-1:0]   i_count,
    input  logic [TIME_BITS-1:0]        i_now,
    input  logic                        i_tok_found,
    input  logic [IDX_BITS-1:0]         i_tok_idx,
    input  logic [TIME_BITS-1:0]        i_tok_dl,
    input  logic                        i_tok_fin,
    output logic                        o_tok_found,
    output logic [IDX_BITS-1:0]         o_tok_idx,
    output logic [TIME_BITS-1:0]        o_tok_dl,
    output logic                        o_tok_fin
);

    localparam logic [TIME_BITS-1:0] TIME_MAX = '1;

    logic [edf_pkg::WORK_W-1:0] r_period, n_period;
    logic [edf_pkg::WORK_W-1:0] r_work, n_work;
    logic [edf_pkg::WORK_W-1:0] r_dline, n_dline;
    logic [edf_pkg::WORK_W-1:0] r_left, n_left;
    logic [TIME_BITS-1:0]       r_release, n_release;

    logic                 r_tok_found, n_tok_found;
    logic [IDX_BITS-1:0]  r_tok_idx, n_tok_idx;
    logic [TIME_BITS-1:0] r_tok_dl, n_tok_dl;
    logic                 r_tok_fin, n_tok_fin;

    logic                 w_enabled;
    logic                 w_eligible;
    logic [TIME_BITS:0]   w_dl_sum;
    logic [TIME_BITS-1:0] w_abs_dl;
    logic [TIME_BITS:0]   w_rel_sum;

    assign w_enabled  = int'(i_count) > CELL_IDX;
    assign w_eligible = w_enabled && (r_release <= i_now) && (r_left != '0);
    assign w_dl_sum   = {1'b0, r_release} + (TIME_BITS+1)'(r_dline);
    assign w_abs_dl   = w_dl_sum[TIME_BITS] ? TIME_MAX : w_dl_sum[TIME_BITS-1:0];
    assign w_rel_sum  = {1'b0, r_release} + (TIME_BITS+1)'(r_period);

    // strict less keeps the lower slot on a tie
    always_comb begin
        n_tok_found = i_tok_found;
        n_tok_idx   = i_tok_idx;
        n_tok_dl    = i_tok_dl;
        n_tok_fin   = i_tok_fin;
        if (w_eligible && (!i_tok_found || (w_abs_dl < i_tok_dl))) begin
            n_tok_found = 1'b1;
            n_tok_idx   = IDX_BITS'(CELL_IDX);
            n_tok_dl    = w_abs_dl;
            n_tok_fin   = (r_left == edf_pkg::WORK_W'(1));
        end
    end

    always_comb begin
        n_period  = r_period;
        n_work    = r_work;
        n_dline   = r_dline;
        n_left    = r_left;
        n_release = r_release;
        if (i_cmd.restart) begin
            n_period  = '0;
            n_work    = '0;
            n_dline   = '0;
            n_left    = '0;
            n_release = '0;
        end else if (i_cmd.load && (int'(i_cmd.slot) == CELL_IDX)) begin
            n_period  = i_cmd.period;
            n_work    = i_cmd.exec_time;
            n_dline   = i_cmd.rel_deadline;
            n_left    = i_cmd.exec_time;
            n_release = '0;
        end else if (i_grant) begin
            if (r_left == edf_pkg::WORK_W'(1)) begin
                n_left    = r_work;
                n_release = w_rel_sum[TIME_BITS] ? TIME_MAX : w_rel_sum[TIME_BITS-1:0];
            end else begin
                n_left = r_left - edf_pkg::WORK_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period    <= '0;
            r_work      <= '0;
            r_dline     <= '0;
            r_left      <= '0;
            r_release   <= '0;
            r_tok_found <= 1'b0;
        end else begin
            r_period    <= n_period;
            r_work      <= n_work;
            r_dline     <= n_dline;
            r_left      <= n_left;
            r_release   <= n_release;
            r_tok_found <= n_tok_found;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tok_idx <= n_tok_idx;
        r_tok_dl  <= n_tok_dl;
        r_tok_fin <= n_tok_fin;
    end

    assign o_tok_found = r_tok_found;
    assign o_tok_idx   = r_tok_idx;
    assign o_tok_dl    = r_tok_dl;
    assign o_tok_fin   = r_tok_fin;

endmodule

// File: bench/tb_top.sv
// self-checking bench for edf_tick_scheduler: a tick-level EDF predictor in a small
// scoreboard class, request and result channels driven with random idling and stalls
// depends on edf_pkg and the edf_tick_scheduler design files
`timescale 1ns / 1ps

module tb_top;

    localparam int SLOTS        = 8;
    localparam int ITEMS_TOTAL  = 450;
    localparam int SETTLE_GAP   = 20;
    localparam int TAIL_GAP     = 30;
    localparam int HOLD_CYCLES  = 400;
    localparam int CYCLE_LIMIT  = 250000;
    localparam logic [1:0] FUNC_UNUSED = 2'd3;

    class edf_tick_tracker;
        logic [edf_pkg::CFG_W-1:0]  count_reg;
        logic [edf_pkg::WORK_W-1:0] period_of [SLOTS];
        logic [edf_pkg::WORK_W-1:0] work_of [SLOTS];
        logic [edf_pkg::WORK_W-1:0] dl_of [SLOTS];
        logic [edf_pkg::WORK_W-1:0] left_of [SLOTS];
        logic [31:0]                release_at [SLOTS];
        logic [31:0]                now_tick;
        edf_pkg::t_out_res          due_ticks[$];
        int                         failures;

        function new();
            count_reg = '0;
            failures  = 0;
            clear_slots();
        endfunction

        function void clear_slots();
            for (int i = 0; i < SLOTS; i++) begin
                period_of[i]  = '0;
                work_of[i]    = '0;
                dl_of[i]      = '0;
                left_of[i]    = '0;
                release_at[i] = '0;
            end
            now_tick = '0;
        endfunction

        function logic [31:0] sat_add(logic [31:0] a, logic [31:0] b);
            logic [32:0] s;
            s = {1'b0, a} + {1'b0, b};
            return s[32] ? '1 : s[31:0];
        endfunction

        function void set_count(logic [edf_pkg::CFG_W-1:0] v);
            count_reg = v;
        endfunction

        function void run_tick();
            int                lim;
            bit                found;
            int                best;
            logic [31:0]       best_dl;
            logic [31:0]       dl;
            edf_pkg::t_out_res res;
            lim     = (count_reg > SLOTS) ? SLOTS : count_reg;
            found   = 1'b0;
            best    = 0;
            best_dl = '0;
            for (int i = 0; i < lim; i++) begin
                if (release_at[i] <= now_tick && left_of[i] != 0) begin
                    dl = sat_add(release_at[i], {16'd0, dl_of[i]});
                    // strict compare keeps the lowest slot on a tie
                    if (!found || dl < best_dl) begin
                        found   = 1'b1;
                        best    = i;
                        best_dl = dl;
                    end
                end
            end
            res             = '0;
            res.idle        = !found;
            res.task_number = found ? best[edf_pkg::SLOT_W-1:0] : '0;
            res.tick_time   = now_tick;
            if (found) begin
                left_of[best] = left_of[best] - 1'b1;
                if (left_of[best] == 0) begin
                    release_at[best] = sat_add(release_at[best], {16'd0, period_of[best]});
                    left_of[best]    = work_of[best];
                    res.job_done     = 1'b1;
                end
            end
            now_tick = sat_add(now_tick, 32'd1);
            due_ticks.push_back(res);
        endfunction

        function void take_request(edf_pkg::t_in_req r);
            case (r.func)
                edf_pkg::FUNC_LOAD: begin
                    period_of[r.task_slot]  = r.period;
                    work_of[r.task_slot]    = r.exec_time;
                    dl_of[r.task_slot]      = r.rel_deadline;
                    left_of[r.task_slot]    = r.exec_time;
                    release_at[r.task_slot] = '0;
                end
                edf_pkg::FUNC_RESTART: clear_slots();
                edf_pkg::FUNC_TICK: run_tick();
                default: ;
            endcase
        endfunction

        function void match_result(edf_pkg::t_out_res got);
            edf_pkg::t_out_res want;
            if (due_ticks.size() == 0) begin
                $error("result with no tick pending: %h", got);
                failures++;
                return;
            end
            want = due_ticks.pop_front();
            if (got.idle !== want.idle) begin
                $error("idle: expected %0d, actual %0d", want.idle, got.idle);
                failures++;
            end
            if (got.task_number !== want.task_number) begin
                $error("task_number: expected %0d, actual %0d",
                       want.task_number, got.task_number);
                failures++;
            end
            if (got.tick_time !== want.tick_time) begin
                $error("tick_time: expected %0d, actual %0d", want.tick_time, got.tick_time);
                failures++;
            end
            if (got.job_done !== want.job_done) begin
                $error("job_done: expected %0d, actual %0d", want.job_done, got.job_done);
                failures++;
            end
        endfunction
    endclass

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       i_cfg_we;
    logic [edf_pkg::CFG_W-1:0]  i_cfg_wdata;
    logic                       i_in_valid;
    logic                       o_in_stall;
    edf_pkg::t_in_req           i_in_req;
    logic                       o_out_valid;
    logic                       i_out_stall;
    edf_pkg::t_out_res          o_out_res;

    edf_tick_tracker   tracker;
    int                send_idle_pct;
    int                recv_stall_pct;
    bit                hold_off_go;
    int                sent_items;
    int                cycles;

    edf_tick_scheduler uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_req    (i_in_req),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_res   (o_out_res)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles >= CYCLE_LIMIT) begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    // result side: random stalls, plus one long hold-off on request
    initial begin
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_off_go) begin
                hold_off_go = 1'b0;
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end else begin
                i_out_stall <= ($urandom_range(99) < recv_stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            tracker.match_result(o_out_res);
    end

    function automatic edf_pkg::t_in_req make_req(logic [1:0] f,
                                                  logic [edf_pkg::SLOT_W-1:0] s,
                                                  logic [edf_pkg::WORK_W-1:0] p,
                                                  logic [edf_pkg::WORK_W-1:0] e,
                                                  logic [edf_pkg::WORK_W-1:0] d);
        edf_pkg::t_in_req r;
        r.func         = f;
        r.task_slot    = s;
        r.period       = p;
        r.exec_time    = e;
        r.rel_deadline = d;
        return r;
    endfunction

    function automatic logic [edf_pkg::WORK_W-1:0] rand16();
        return edf_pkg::WORK_W'($urandom);
    endfunction

    function automatic edf_pkg::t_in_req rand_req(logic [1:0] f);
        return make_req(f, edf_pkg::SLOT_W'($urandom), rand16(), rand16(), rand16());
    endfunction

    // valid stays high after acceptance until the next negedge decides
    task automatic send_req(input edf_pkg::t_in_req r);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_req   <= r;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        tracker.take_request(r);
        if (r.func != FUNC_UNUSED)
            sent_items++;
    endtask

    task automatic settle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (tracker.due_ticks.size() != 0) @(posedge i_clk);
        repeat (SETTLE_GAP) @(posedge i_clk);
    endtask

    task automatic write_count(input logic [edf_pkg::CFG_W-1:0] v);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        tracker.set_count(v);
    endtask

    task automatic send_load();
        if ($urandom_range(9) == 0)
            send_req(rand_req(edf_pkg::FUNC_LOAD));
        else
            send_req(make_req(edf_pkg::FUNC_LOAD, edf_pkg::SLOT_W'($urandom),
                              edf_pkg::WORK_W'($urandom_range(0, 24)),
                              edf_pkg::WORK_W'($urandom_range(1, 4)),
                              edf_pkg::WORK_W'($urandom_range(0, 30))));
    endtask

    // mostly restart/load/tick sequences, some raw noise
    task automatic run_batch();
        int left;
        left = $urandom_range(30, 45);
        while (left > 0) begin
            if ($urandom_range(99) < 80) begin
                if ($urandom_range(1)) begin
                    send_req(rand_req(edf_pkg::FUNC_RESTART));
                    left--;
                end
                repeat ($urandom_range(1, 4)) begin
                    send_load();
                    left--;
                end
                repeat ($urandom_range(5, 20)) begin
                    send_req(rand_req(edf_pkg::FUNC_TICK));
                    left--;
                end
            end else begin
                send_req(rand_req(2'($urandom)));
                left--;
            end
        end
    endtask

    initial begin
        logic [edf_pkg::CFG_W-1:0] count_plan [12];
        int                        batch;
        bit                        held;
        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_wdata    = '0;
        i_in_valid     = 1'b0;
        i_in_req       = '0;
        send_idle_pct  = 10;
        recv_stall_pct = 67;
        hold_off_go    = 1'b0;
        sent_items     = 0;
        batch          = 0;
        held           = 1'b0;
        count_plan     = '{4'd0, 4'd1, 4'd3, 4'd8, 4'd9, 4'd15,
                           4'd5, 4'd8, 4'd2, 4'd8, 4'd7, 4'd15};
        tracker        = new();
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        write_count(4'd8);
        send_req(make_req(edf_pkg::FUNC_TICK, 3'd0, 16'h0000, 16'h0000, 16'h0000));
        send_req(make_req(edf_pkg::FUNC_LOAD, 3'd0, 16'd4, 16'd2, 16'd4));
        send_req(make_req(edf_pkg::FUNC_LOAD, 3'd7, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        // zero work per job never runs
        send_req(make_req(edf_pkg::FUNC_LOAD, 3'd3, 16'd0, 16'd0, 16'd0));
        send_req(make_req(edf_pkg::FUNC_LOAD, 3'd1, 16'd5, 16'd1, 16'd3));
        send_req(make_req(edf_pkg::FUNC_LOAD, 3'd2, 16'd0, 16'd1, 16'h8000));
        send_req(make_req(FUNC_UNUSED, 3'd7, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        repeat (8)
            send_req(make_req(edf_pkg::FUNC_TICK, 3'd5, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        send_req(make_req(edf_pkg::FUNC_RESTART, 3'd7, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        send_req(make_req(edf_pkg::FUNC_TICK, 3'd0, 16'h0000, 16'h0000, 16'h0000));
        settle();

        // count above the slot total acts as all slots; equal deadlines tie
        write_count(4'd15);
        send_req(make_req(edf_pkg::FUNC_LOAD, 3'd7, 16'd3, 16'd1, 16'd2));
        send_req(make_req(edf_pkg::FUNC_LOAD, 3'd6, 16'd3, 16'd1, 16'd2));
        repeat (4) send_req(make_req(edf_pkg::FUNC_TICK, 3'd0, 16'd0, 16'd0, 16'd0));
        settle();

        while (sent_items < ITEMS_TOTAL) begin
            if (sent_items < 170) begin
                send_idle_pct  = 10;
                recv_stall_pct = 67;
            end else if (sent_items < 310) begin
                send_idle_pct  = 67;
                recv_stall_pct = 10;
            end else begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
            write_count(count_plan[batch % 12]);
            if (send_idle_pct == 0 && !held) begin
                // sender keeps offering while results back up
                hold_off_go = 1'b1;
                held        = 1'b1;
            end
            run_batch();
            settle();
            batch++;
        end

        repeat (TAIL_GAP) @(posedge i_clk);
        if (tracker.failures == 0 && tracker.due_ticks.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
